FILE: rtl/smtq_pkg.sv
// sorted multi-timer queue: shared constants, action codes and compare flags
// used by the top level and by the saturating add / compare unit
package smtq_pkg;

  localparam int SLOTS         = 16;
  localparam int TIME_BITS     = 48;
  localparam int INTERVAL_BITS = 24;
  localparam int ID_W          = 4;
  localparam int CNT_W         = 5;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

FILE: rtl/sorted_multi_timer_queue_unit.sv
// sorted multi-timer queue, top level: sequencer, slot flags, sorted queue
// depends on smtq_pkg, smtq_alu and smtq_ram
//
// Usage: drive in_action / in_timer_id / in_interval_ticks / in_periodic and
// raise start; the item is taken at a clock edge with start high and busy
// low. Actions: tick (advance time by one and fire due timers), start timer,
// stop timer. Busy stays high until the item is fully handled.
// Results: one per firing, shown for exactly one cycle with out_valid high;
// out_last_fire marks the final firing of a tick. The receiver cannot stall,
// so results are never held back.
// Steps: stop, an unused action and an ignored start are handled in idle.
// A start walks the sorted queue from the head, a check and a compare for
// each entry passed, then puts the new entry in. A tick first counts the due
// entries at the queue head, then pops each due entry, fires it if still
// active and re-queues a periodic one by the same sorted walk, and ends with
// a closing step that shows the held last firing. Each step shares the one
// deadline ram read port and one shared adder/comparator, used once per step.
// Reset (synchronous, active low) empties the queue, clears all slot flags
// and sets time to zero; deadline and interval stores need no clearing.
module sorted_multi_timer_queue_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_action,
  input  logic [smtq_pkg::ID_W-1:0]          in_timer_id,
  input  logic [smtq_pkg::INTERVAL_BITS-1:0] in_interval_ticks,
  input  logic                               in_periodic,
  output logic                               out_valid,
  output logic [smtq_pkg::ID_W-1:0]          out_fired_id,
  output logic [smtq_pkg::TIME_BITS-1:0]     out_fire_deadline,
  output logic                               out_last_fire
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CNT_CHK, ST_CNT_CMP, ST_POP_CHK, ST_POP_EXE,
    ST_INS_CHK, ST_INS_CMP, ST_INS_PUT
  } state_t;

  localparam int TB = smtq_pkg::TIME_BITS;
  localparam int IB = smtq_pkg::INTERVAL_BITS;
  localparam int IW = smtq_pkg::ID_W;
  localparam int CW = smtq_pkg::CNT_W;
  localparam int NS = smtq_pkg::SLOTS;

  state_t state_r, state_nxt;

  logic [TB-1:0] now_r, now_nxt;
  logic [TB-1:0] key_r, key_nxt;
  logic [IW-1:0] q_r [NS];
  logic [IW-1:0] q_nxt [NS];
  logic [CW-1:0] qlen_r, qlen_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] hd_id_r, hd_id_nxt;
  logic [IW-1:0] ins_id_r, ins_id_nxt;
  logic          tick_r, tick_nxt;
  logic [NS-1:0] active_r, active_nxt;
  logic [NS-1:0] periodic_r, periodic_nxt;
  logic [NS-1:0] started_r, started_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [IW-1:0] pend_id_r, pend_id_nxt;
  logic [TB-1:0] pend_dl_r, pend_dl_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [IW-1:0] out_id_r, out_id_nxt;
  logic [TB-1:0] out_dl_r, out_dl_nxt;
  logic          out_last_r, out_last_nxt;

  logic          dl_we;
  logic [IW-1:0] dl_waddr, dl_raddr;
  logic [TB-1:0] dl_wdata, dl_rdata;
  logic          iv_we;
  logic [IB-1:0] iv_wdata, iv_rdata;

  logic [TB-1:0]  add_a, add_b, sum;
  smtq_pkg::cmp_t cmp;
  logic [IB-1:0]  iv_fixed;

  smtq_ram #(.WIDTH(TB), .DEPTH(NS)) u_dl_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  smtq_ram #(.WIDTH(IB), .DEPTH(NS)) u_iv_ram (
    .clk   (clk),
    .we    (iv_we),
    .waddr (in_timer_id),
    .wdata (iv_wdata),
    .raddr (q_r[0]),
    .rdata (iv_rdata)
  );

  smtq_alu u_alu (
    .add_a (add_a),
    .add_b (add_b),
    .cmp_a (dl_rdata),
    .cmp_b (key_r),
    .sum   (sum),
    .cmp   (cmp)
  );

  // a zero interval counts as one tick
  assign iv_fixed = (in_interval_ticks == '0) ? IB'(1) : in_interval_ticks;

  always_comb begin
    state_nxt    = state_r;
    now_nxt      = now_r;
    key_nxt      = key_r;
    q_nxt        = q_r;
    qlen_nxt     = qlen_r;
    k_nxt        = k_r;
    pos_nxt      = pos_r;
    hd_id_nxt    = hd_id_r;
    ins_id_nxt   = ins_id_r;
    tick_nxt     = tick_r;
    active_nxt   = active_r;
    periodic_nxt = periodic_r;
    started_nxt  = started_r;
    pend_v_nxt   = pend_v_r;
    pend_id_nxt  = pend_id_r;
    pend_dl_nxt  = pend_dl_r;
    out_valid_nxt = 1'b0;
    out_id_nxt   = out_id_r;
    out_dl_nxt   = out_dl_r;
    out_last_nxt = out_last_r;

    dl_we    = 1'b0;
    dl_waddr = in_timer_id;
    dl_wdata = sum;
    dl_raddr = q_r[0];
    iv_we    = 1'b0;
    iv_wdata = iv_fixed;

    add_a = dl_rdata;
    add_b = TB'(iv_rdata);

    unique case (state_r)
      ST_IDLE: begin
        add_a = now_r;
        add_b = (in_action == smtq_pkg::ACT_TICK) ? TB'(1) : TB'(iv_fixed);
        if (start) begin
          unique case (in_action)
            smtq_pkg::ACT_TICK: begin
              now_nxt   = sum;
              key_nxt   = sum;
              k_nxt     = '0;
              tick_nxt  = 1'b1;
              state_nxt = ST_CNT_CHK;
            end
            smtq_pkg::ACT_START: begin
              // a slot is armed only once, later starts are ignored
              if (!started_r[in_timer_id]) begin
                started_nxt[in_timer_id]  = 1'b1;
                active_nxt[in_timer_id]   = 1'b1;
                periodic_nxt[in_timer_id] = in_periodic;
                dl_we      = 1'b1;
                iv_we      = 1'b1;
                key_nxt    = sum;
                ins_id_nxt = in_timer_id;
                pos_nxt    = '0;
                tick_nxt   = 1'b0;
                state_nxt  = ST_INS_CHK;
              end
            end
            smtq_pkg::ACT_STOP: begin
              active_nxt[in_timer_id] = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      // count the due entries at the queue head
      ST_CNT_CHK: begin
        dl_raddr = q_r[k_r[IW-1:0]];
        if (k_r == qlen_r) begin
          state_nxt = ST_POP_CHK;
        end else begin
          state_nxt = ST_CNT_CMP;
        end
      end

      ST_CNT_CMP: begin
        if (cmp.lt || cmp.eq) begin
          k_nxt     = k_r + CW'(1);
          state_nxt = ST_CNT_CHK;
        end else begin
          state_nxt = ST_POP_CHK;
        end
      end

      ST_POP_CHK: begin
        dl_raddr = q_r[0];
        if (k_r == '0) begin
          // no due entry left: the held firing is the last of this tick
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = pend_id_r;
            out_dl_nxt    = pend_dl_r;
            out_last_nxt  = 1'b1;
            pend_v_nxt    = 1'b0;
          end
          tick_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          hd_id_nxt = q_r[0];
          for (int j = 0; j < NS - 1; j++) begin
            q_nxt[j] = q_r[j+1];
          end
          qlen_nxt  = qlen_r - CW'(1);
          k_nxt     = k_r - CW'(1);
          state_nxt = ST_POP_EXE;
        end
      end

      ST_POP_EXE: begin
        dl_waddr  = hd_id_r;
        state_nxt = ST_POP_CHK;
        if (active_r[hd_id_r]) begin
          // hold each firing until the next one is found so the last one can be marked
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = pend_id_r;
            out_dl_nxt    = pend_dl_r;
            out_last_nxt  = 1'b0;
          end
          pend_v_nxt  = 1'b1;
          pend_id_nxt = hd_id_r;
          pend_dl_nxt = dl_rdata;
          if (periodic_r[hd_id_r]) begin
            // re-queue behind the due entries still waiting in this tick
            dl_we      = 1'b1;
            key_nxt    = sum;
            ins_id_nxt = hd_id_r;
            pos_nxt    = k_r;
            state_nxt  = ST_INS_CHK;
          end
        end
      end

      ST_INS_CHK: begin
        dl_raddr = q_r[pos_r[IW-1:0]];
        if (pos_r == qlen_r) begin
          state_nxt = ST_INS_PUT;
        end else begin
          state_nxt = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        if (cmp.lt) begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = ST_INS_CHK;
        end else begin
          state_nxt = ST_INS_PUT;
        end
      end

      ST_INS_PUT: begin
        for (int j = 0; j < NS; j++) begin
          if (CW'(j) == pos_r) begin
            q_nxt[j] = ins_id_r;
          end else if (j > 0 && CW'(j) > pos_r) begin
            q_nxt[j] = q_r[(j > 0) ? j - 1 : 0];
          end
        end
        qlen_nxt  = qlen_r + CW'(1);
        state_nxt = tick_r ? ST_POP_CHK : ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      qlen_r      <= '0;
      k_r         <= '0;
      tick_r      <= 1'b0;
      active_r    <= '0;
      periodic_r  <= '0;
      started_r   <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      qlen_r      <= qlen_nxt;
      k_r         <= k_nxt;
      tick_r      <= tick_nxt;
      active_r    <= active_nxt;
      periodic_r  <= periodic_nxt;
      started_r   <= started_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    q_r        <= q_nxt;
    pos_r      <= pos_nxt;
    hd_id_r    <= hd_id_nxt;
    ins_id_r   <= ins_id_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_dl_r  <= pend_dl_nxt;
    out_id_r   <= out_id_nxt;
    out_dl_r   <= out_dl_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_fired_id      = out_id_r;
  assign out_fire_deadline = out_dl_r;
  assign out_last_fire     = out_last_r;

endmodule

FILE: rtl/smtq_ram.sv
// generic single-write, single-read ram with registered read data
// no package dependency
module smtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/smtq_alu.sv
// shared arithmetic unit: saturating time add and one magnitude compare
// depends on smtq_pkg
module smtq_alu (
  input  logic [smtq_pkg::TIME_BITS-1:0] add_a,
  input  logic [smtq_pkg::TIME_BITS-1:0] add_b,
  input  logic [smtq_pkg::TIME_BITS-1:0] cmp_a,
  input  logic [smtq_pkg::TIME_BITS-1:0] cmp_b,
  output logic [smtq_pkg::TIME_BITS-1:0] sum,
  output smtq_pkg::cmp_t                 cmp
);

  logic [smtq_pkg::TIME_BITS:0] raw;

  always_comb begin
    raw = {1'b0, add_a} + {1'b0, add_b};
    // carry out means the sum passed the largest time value
    sum = raw[smtq_pkg::TIME_BITS] ? {smtq_pkg::TIME_BITS{1'b1}}
                                   : raw[smtq_pkg::TIME_BITS-1:0];
    cmp.lt = (cmp_a < cmp_b);
    cmp.eq = (cmp_a == cmp_b);
  end

endmodule

FILE: tb/sorted_multi_timer_queue_unit_test.sv
`timescale 1ns / 1ps
// testbench for sorted_multi_timer_queue_unit: directed and random ticks, starts and stops,
// with an in-bench timer queue predictor; depends on smtq_pkg and the unit's rtl
module sorted_multi_timer_queue_unit_test;

  localparam int SLOTS         = smtq_pkg::SLOTS;
  localparam int TIME_BITS     = smtq_pkg::TIME_BITS;
  localparam int INTERVAL_BITS = smtq_pkg::INTERVAL_BITS;
  localparam int ID_W          = smtq_pkg::ID_W;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int MAX_FIRES_PER_TICK = 16;

  typedef struct packed {
    logic [ID_W-1:0]      slot;
    logic [TIME_BITS-1:0] deadline;
    logic                 last_fire;
  } fire_t;

  class timer_queue_scoreboard;
    logic [TIME_BITS-1:0]     now_tick = '0;
    logic [TIME_BITS-1:0]     slot_deadline [SLOTS];
    logic [INTERVAL_BITS-1:0] slot_interval [SLOTS];
    bit                       slot_periodic [SLOTS];
    bit                       slot_active [SLOTS];
    bit                       slot_started [SLOTS];
    logic [ID_W-1:0]          deadline_order[$];
    fire_t                    expected_fires[$];
    int                       errors = 0;
    int                       fires_checked = 0;

    function logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    endfunction

    // new entry goes ahead of any entry with an equal or later deadline
    function void enqueue_slot(logic [ID_W-1:0] id);
      int pos;
      pos = 0;
      if (deadline_order.size() >= SLOTS) return;
      while (pos < deadline_order.size() &&
             slot_deadline[deadline_order[pos]] < slot_deadline[id])
        pos++;
      deadline_order.insert(pos, id);
    endfunction

    function void note_item(logic [1:0] act, logic [ID_W-1:0] id,
                            logic [INTERVAL_BITS-1:0] ival, logic per);
      logic [ID_W-1:0] due_slots[$];
      logic [ID_W-1:0] held_slots[$];
      logic [ID_W-1:0] s;
      fire_t           f;
      int              fired;
      fired = 0;
      case (act)
        smtq_pkg::ACT_START: begin
          if (!slot_started[id]) begin
            slot_started[id]  = 1'b1;
            slot_interval[id] = (ival == '0) ? INTERVAL_BITS'(1) : ival;
            slot_periodic[id] = per;
            slot_deadline[id] = sat_add(now_tick, TIME_BITS'(slot_interval[id]));
            slot_active[id]   = 1'b1;
            enqueue_slot(id);
          end
        end
        smtq_pkg::ACT_STOP: slot_active[id] = 1'b0;
        smtq_pkg::ACT_TICK: begin
          now_tick = sat_add(now_tick, TIME_BITS'(1));
          while (deadline_order.size() > 0 && slot_deadline[deadline_order[0]] <= now_tick) begin
            due_slots.insert(due_slots.size(), deadline_order[0]);
            deadline_order.delete(0);
          end
          foreach (due_slots[i]) begin
            s = due_slots[i];
            if (!slot_active[s]) continue;
            if (fired >= MAX_FIRES_PER_TICK) begin
              held_slots.insert(held_slots.size(), s);
              continue;
            end
            f.slot      = s;
            f.deadline  = slot_deadline[s];
            f.last_fire = 1'b0;
            expected_fires.insert(expected_fires.size(), f);
            fired++;
            // re-queued from the old deadline so periodic timers do not drift
            if (slot_periodic[s]) begin
              slot_deadline[s] = sat_add(slot_deadline[s], TIME_BITS'(slot_interval[s]));
              enqueue_slot(s);
            end
          end
          for (int i = held_slots.size() - 1; i >= 0; i--)
            deadline_order.push_front(held_slots[i]);
          if (fired > 0)
            expected_fires[expected_fires.size() - 1].last_fire = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_fire(logic [ID_W-1:0] id, logic [TIME_BITS-1:0] deadline, logic last);
      fire_t exp_fire;
      fires_checked++;
      if (expected_fires.size() == 0) begin
        note_error($sformatf("unexpected fire: id %0d deadline %0d last %0b",
                             id, deadline, last));
        return;
      end
      exp_fire = expected_fires[0];
      expected_fires.delete(0);
      if (exp_fire.slot !== id || exp_fire.deadline !== deadline ||
          exp_fire.last_fire !== last)
        note_error($sformatf({"fire mismatch: expected id %0d deadline %0d last %0b,",
                              " got %0d %0d %0b"},
                             exp_fire.slot, exp_fire.deadline, exp_fire.last_fire,
                             id, deadline, last));
    endfunction

    function int pending();
      return expected_fires.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_action = smtq_pkg::ACT_TICK;
  logic [ID_W-1:0]          in_timer_id = '0;
  logic [INTERVAL_BITS-1:0] in_interval_ticks = '0;
  logic                     in_periodic = 1'b0;
  logic                     out_valid;
  logic [ID_W-1:0]          out_fired_id;
  logic [TIME_BITS-1:0]     out_fire_deadline;
  logic                     out_last_fire;

  timer_queue_scoreboard sb = new;

  sorted_multi_timer_queue_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_timer_id      (in_timer_id),
    .in_interval_ticks(in_interval_ticks),
    .in_periodic      (in_periodic),
    .out_valid        (out_valid),
    .out_fired_id     (out_fired_id),
    .out_fire_deadline(out_fire_deadline),
    .out_last_fire    (out_last_fire)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_fire(out_fired_id, out_fire_deadline, out_last_fire);
  end

  task automatic send_item(input logic [1:0] act, input logic [ID_W-1:0] id,
                           input logic [INTERVAL_BITS-1:0] ival, input logic per);
    in_action         <= act;
    in_timer_id       <= id;
    in_interval_ticks <= ival;
    in_periodic       <= per;
    start             <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(act, id, ival, per);
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_random_item(input bit allow_idle);
    int                       pick;
    logic [1:0]               act;
    logic [INTERVAL_BITS-1:0] ival;
    pick = $urandom_range(0, 99);
    if (pick < 72)      act = smtq_pkg::ACT_TICK;
    else if (pick < 92) act = smtq_pkg::ACT_START;
    else if (pick < 96) act = smtq_pkg::ACT_STOP;
    else                act = ACT_UNUSED;
    // mostly short intervals so timers keep firing, now and then a full-width one
    ival = ($urandom_range(0, 7) == 0) ? INTERVAL_BITS'($urandom)
                                       : INTERVAL_BITS'($urandom_range(0, 6));
    send_item(act, ID_W'($urandom_range(0, SLOTS - 1)), ival, 1'($urandom_range(0, 1)));
    maybe_idle(allow_idle);
  endtask

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int rand_items;
    int wait_cycles;
    rand_items = 0;
    wait_cycles = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(smtq_pkg::ACT_TICK, 4'd0, '0, 1'b0);          // tick on an empty queue
    send_item(smtq_pkg::ACT_START, 4'd0, '0, 1'b1);         // zero interval raised to one
    maybe_idle(1'b1);
    send_item(smtq_pkg::ACT_START, 4'd1, 24'd3, 1'b0);
    send_item(smtq_pkg::ACT_START, 4'd2, 24'd3, 1'b1);      // equal deadline goes ahead of slot 1
    send_item(smtq_pkg::ACT_START, 4'd3, '1, 1'b0);         // widest interval
    send_item(smtq_pkg::ACT_START, 4'd0, 24'd5, 1'b0);      // restart is ignored
    send_item(ACT_UNUSED, '1, '1, 1'b1);
    maybe_idle(1'b1);
    repeat (3) send_item(smtq_pkg::ACT_TICK, 4'd0, '0, 1'b0);
    send_item(smtq_pkg::ACT_START, 4'd4, 24'd2, 1'b1);
    send_item(smtq_pkg::ACT_STOP, 4'd1, '0, 1'b0);
    send_item(smtq_pkg::ACT_STOP, 4'd4, '0, 1'b0);          // stopped entry dropped silently
    repeat (2) send_item(smtq_pkg::ACT_TICK, 4'd0, '0, 1'b0);
    send_item(smtq_pkg::ACT_START, 4'd4, 24'd1, 1'b1);      // no restart after a stop
    send_item(smtq_pkg::ACT_STOP, 4'd15, '0, 1'b0);
    send_item(smtq_pkg::ACT_START, 4'd5, 24'd1, 1'b1);
    send_item(smtq_pkg::ACT_START, 4'd6, 24'd1, 1'b0);
    maybe_idle(1'b1);
    repeat (3) send_item(smtq_pkg::ACT_TICK, 4'd0, '0, 1'b0);

    while (rand_items < 400) begin
      send_random_item(rand_items < 330);
      rand_items++;
    end
    start <= 1'b0;

    while (sb.pending() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (700) @(posedge clk);
    if (sb.pending() != 0)
      sb.note_error($sformatf("%0d expected fires never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/smtq_pkg.sv
rtl/smtq_ram.sv
rtl/smtq_alu.sv
rtl/sorted_multi_timer_queue_unit.sv
tb/sorted_multi_timer_queue_unit_test.sv
